>>> rtl/edge_aware_box_blur_defines.svh
// Assertion macros shared by the edge-aware box blur RTL.
`ifndef EDGE_AWARE_BOX_BLUR_DEFINES_SVH
`define EDGE_AWARE_BOX_BLUR_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define EABB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define EABB_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/eabb_pkg.sv
// Package with shared types, constants and register codes of the box blur.
package eabb_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int FIFO_DEPTH_DEF = 8;
  localparam int RESET_WIDTH    = 2048;

  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 12;
  localparam int IN_ROW_W   = ROW_W + 1;
  localparam int PIX_W      = 24;
  localparam int SUM_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic row_lo;
    logic row_hi;
    logic col_lo;
    logic col_hi;
    pix_t pix;
  } issue_t;

  typedef struct packed {
    logic last;
    pix_t pix;
  } result_t;

endpackage

>>> rtl/eabb_line_mem.sv
// Line store memory holding the upper and lower line side by side, with a registered read.
module eabb_line_mem #(
  parameter int DEPTH = eabb_pkg::MAX_WIDTH_DEF,
  parameter int AW    = 11,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/eabb_seq.sv
// Frame sequencer: configuration, position counters, item intake and result credits.
`include "edge_aware_box_blur_defines.svh"
module eabb_seq #(
  parameter int MAX_WIDTH  = eabb_pkg::MAX_WIDTH_DEF,
  parameter int FIFO_DEPTH = eabb_pkg::FIFO_DEPTH_DEF,
  parameter int CW         = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [eabb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eabb_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [eabb_pkg::PIX_W-1:0]     in_tdata,
  input  logic                           in_tuser,
  input  logic                           pop,
  output logic                           iss_v,
  output eabb_pkg::issue_t               iss,
  output logic [CW-1:0]                  iss_addr
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int W_RST = (eabb_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : eabb_pkg::RESET_WIDTH;
  localparam logic [CW-1:0] WM1_RST = CW'(W_RST - 1);

  logic [CW-1:0]                   wm1_r, wm1_nxt;
  logic [eabb_pkg::ROW_W-1:0]      hm1_r, hm1_nxt;
  logic [CW-1:0]                   in_col_r, in_col_nxt;
  logic [eabb_pkg::IN_ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [CW-1:0]                   out_col_r, out_col_nxt;
  logic [eabb_pkg::ROW_W-1:0]      out_row_r, out_row_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            acc, in_frame, ign, emit, last, take, frame_end;

  assign in_tready = (cnt_r < CNT_W'(FIFO_DEPTH));
  assign acc       = in_tvalid && in_tready;
  assign in_frame  = (in_row_r <= eabb_pkg::IN_ROW_W'(hm1_r));
  assign ign       = in_frame && in_tuser;
  assign take      = acc && !ign;
  assign emit      = (in_row_r >= eabb_pkg::IN_ROW_W'(2)) ||
                     ((in_row_r == eabb_pkg::IN_ROW_W'(1)) && (in_col_r != '0));
  assign last      = (out_row_r >= hm1_r) && (out_col_r >= wm1_r);
  assign frame_end = take && emit && last;

  always_comb begin
    wm1_nxt     = wm1_r;
    hm1_nxt     = hm1_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (in_col_r >= wm1_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + eabb_pkg::IN_ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (out_col_r >= wm1_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + eabb_pkg::ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
      if (frame_end) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        eabb_pkg::REG_FRAME_WIDTH: begin
          if (cfg_wdata == '0) begin
            wm1_nxt = '0;
          end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            wm1_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            wm1_nxt = CW'(cfg_wdata - eabb_pkg::CFG_W'(1));
          end
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        eabb_pkg::REG_FRAME_HEIGHT: begin
          hm1_nxt     = (cfg_wdata == '0) ? '0 : (cfg_wdata - eabb_pkg::CFG_W'(1));
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (take && emit) begin
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r     <= WM1_RST;
      hm1_r     <= '0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      cnt_r     <= '0;
    end else begin
      wm1_r     <= wm1_nxt;
      hm1_r     <= hm1_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  assign iss_v      = take;
  assign iss_addr   = in_col_r;
  assign iss.emit   = emit;
  assign iss.last   = last;
  assign iss.row_lo = (out_row_r != '0);
  assign iss.row_hi = (out_row_r < hm1_r);
  assign iss.col_lo = (out_col_r != '0);
  assign iss.col_hi = (out_col_r < wm1_r);
  assign iss.pix    = in_frame ? in_tdata : '0;

  `EABB_ASSERT(a_credit_bound, cnt_r <= CNT_W'(FIFO_DEPTH), "result credit count overran the queue depth")
  `EABB_ASSERT(a_restart_on_last, frame_end && !cfg_we |=> (in_row_r == '0) && (out_row_r == '0), "frame did not restart after its final result")
  `EABB_NEVER(a_col_in_range, in_col_r > wm1_r, "input column beyond line width")

endmodule

>>> rtl/eabb_window.sv
// Line store read-modify-write, 3x3 window, neighbor sums and rounded mean.
`include "edge_aware_box_blur_defines.svh"
module eabb_window #(
  parameter int CW = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       iss_v,
  input  eabb_pkg::issue_t           iss,
  input  logic [CW-1:0]              iss_addr,
  output logic [CW-1:0]              mem_rd_addr,
  input  logic [2*eabb_pkg::PIX_W-1:0] mem_rd_data,
  output logic                       mem_wr_en,
  output logic [CW-1:0]              mem_wr_addr,
  output logic [2*eabb_pkg::PIX_W-1:0] mem_wr_data,
  output logic                       push,
  output eabb_pkg::result_t          push_data
);

  localparam int PW = eabb_pkg::PIX_W;
  localparam int SW = eabb_pkg::SUM_W;
  localparam logic [16:0] RECIP_1 = 17'd65536;
  localparam logic [16:0] RECIP_3 = 17'd21846;
  localparam logic [16:0] RECIP_9 = 17'd7282;

  logic                   s1_v_r;
  eabb_pkg::issue_t       s1_r;
  logic [CW-1:0]          s1_addr_r;
  logic                   wr_v_r;
  logic [CW-1:0]          wr_addr_r;
  logic [2*PW-1:0]        wr_data_r;
  logic [2*PW-1:0]        ent;
  eabb_pkg::pix_t         win_r [9];
  logic                   s2_v_r;
  eabb_pkg::issue_t       s2_r;
  logic                   s3_v_r;
  logic                   s3_last_r;
  logic [SW-1:0]          s3_sum_r [3];
  logic [3:0]             s3_n_r;
  logic [1:0]             s3_shift_r;
  logic [16:0]            s3_recip_r;
  logic [SW-1:0]          sum [3];
  logic [2:0]             row_ok, col_ok;
  logic [1:0]             rows, cols;
  logic [3:0]             n_val;
  logic [1:0]             shift_val;
  logic [16:0]            recip_val;
  logic [SW:0]            num [3];
  logic [SW:0]            quo [3];
  logic [29:0]            prod [3];

  assign mem_rd_addr = iss_addr;
  assign ent         = (wr_v_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : mem_rd_data;
  assign mem_wr_en   = s1_v_r;
  assign mem_wr_addr = s1_addr_r;
  assign mem_wr_data = {ent[PW-1:0], s1_r.pix};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wr_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_v_r <= iss_v;
      wr_v_r <= s1_v_r;
      s2_v_r <= s1_v_r && s1_r.emit;
      s3_v_r <= s2_v_r;
      if (s1_v_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]     <= win_r[r*3+1];
          win_r[r*3 + 1] <= win_r[r*3+2];
        end
        win_r[2] <= ent[2*PW-1:PW];
        win_r[5] <= ent[PW-1:0];
        win_r[8] <= s1_r.pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= iss;
    s1_addr_r  <= iss_addr;
    wr_addr_r  <= s1_addr_r;
    wr_data_r  <= mem_wr_data;
    s2_r       <= s1_r;
    s3_last_r  <= s2_r.last;
    s3_n_r     <= n_val;
    s3_shift_r <= shift_val;
    s3_recip_r <= recip_val;
    for (int ch = 0; ch < 3; ch++) begin
      s3_sum_r[ch] <= sum[ch];
    end
  end

  assign row_ok = {s2_r.row_hi, 1'b1, s2_r.row_lo};
  assign col_ok = {s2_r.col_hi, 1'b1, s2_r.col_lo};
  assign rows   = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
  assign cols   = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          if (row_ok[r] && col_ok[k]) begin
            sum[ch] = sum[ch] + SW'(win_r[r*3+k][8*ch +: 8]);
          end
        end
      end
    end
  end

  always_comb begin
    n_val     = 4'(rows) * 4'(cols);
    shift_val = 2'd1 + 2'(rows == 2'd2) + 2'(cols == 2'd2);
    case (2'(rows == 2'd3) + 2'(cols == 2'd3))
      2'd0:    recip_val = RECIP_1;
      2'd1:    recip_val = RECIP_3;
      default: recip_val = RECIP_9;
    endcase
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {s3_sum_r[ch], 1'b0} + (SW+1)'(s3_n_r);
      quo[ch]  = num[ch] >> s3_shift_r;
      prod[ch] = {17'd0, quo[ch]} * {13'd0, s3_recip_r};
    end
  end

  assign push           = s3_v_r;
  assign push_data.last = s3_last_r;
  assign push_data.pix  = {prod[2][16 +: 8], prod[1][16 +: 8], prod[0][16 +: 8]};

  `EABB_ASSERT(a_n_legal, s3_v_r |-> (s3_n_r == 4'd1 || s3_n_r == 4'd2 || s3_n_r == 4'd3 || s3_n_r == 4'd4 || s3_n_r == 4'd6 || s3_n_r == 4'd9), "neighbor count outside the legal set")

endmodule

>>> rtl/eabb_out_fifo.sv
// Result queue between the blur pipeline and the output channel.
`include "edge_aware_box_blur_defines.svh"
module eabb_out_fifo #(
  parameter int DEPTH = eabb_pkg::FIFO_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  eabb_pkg::result_t        push_data,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [eabb_pkg::PIX_W-1:0] out_tdata,
  output logic                     out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  eabb_pkg::result_t q_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pop;

  assign out_tvalid = (count_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = q_r[rd_ptr_r].pix;
  assign out_tlast  = q_r[rd_ptr_r].last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      count_nxt  = count_nxt + CNT_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      count_nxt  = count_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  `EABB_NEVER(a_fifo_overflow, push && !pop && (count_r == CNT_W'(DEPTH)), "result queue overflow")

endmodule

>>> rtl/edge_aware_box_blur.sv
// Top level of the streaming 3x3 box blur with frame-edge aware averaging.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_tvalid/in_tready | in_tdata pixel, in_tuser drain flag
//   out_    | output    | out_tvalid/out_tready | out_tdata pixel, out_tlast frame end
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One item is taken per cycle while fewer than FIFO_DEPTH results are pending.
// A result passes through the s1, s2 and s3 registers on its way to the output queue.
// Both line stores share one memory entry per column, read as an item is issued and
// written back the next cycle, with a forward path for back-to-back same-column use.
// Reset is synchronous; the line memory itself is not cleared.
// A stalled output fills the queue, and in_tready drops as the pending results reach FIFO_DEPTH.
module edge_aware_box_blur #(
  parameter int MAX_WIDTH  = eabb_pkg::MAX_WIDTH_DEF,
  parameter int FIFO_DEPTH = eabb_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [eabb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eabb_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [eabb_pkg::PIX_W-1:0]     in_tdata,   // in_red, in_green, in_blue
  input  logic                           in_tuser,   // drain
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [eabb_pkg::PIX_W-1:0]     out_tdata,  // out_red, out_green, out_blue
  output logic                           out_tlast
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = 2 * eabb_pkg::PIX_W;

  logic                 iss_v;
  eabb_pkg::issue_t     iss;
  logic [CW-1:0]        iss_addr;
  logic [CW-1:0]        mem_rd_addr;
  logic [EW-1:0]        mem_rd_data;
  logic                 mem_wr_en;
  logic [CW-1:0]        mem_wr_addr;
  logic [EW-1:0]        mem_wr_data;
  logic                 push;
  eabb_pkg::result_t    push_data;
  logic                 pop;

  assign pop = out_tvalid && out_tready;

  eabb_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .FIFO_DEPTH (FIFO_DEPTH),
    .CW         (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop       (pop),
    .iss_v     (iss_v),
    .iss       (iss),
    .iss_addr  (iss_addr)
  );

  eabb_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (EW)
  ) u_line_mem (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  eabb_window #(
    .CW (CW)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .iss_v       (iss_v),
    .iss         (iss),
    .iss_addr    (iss_addr),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .push        (push),
    .push_data   (push_data)
  );

  eabb_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> bench/box_blur_checker.sv
// Checker for the box blur: predicts each blurred pixel and compares it with the output channel.
`timescale 1ns / 100ps

module box_blur_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [eabb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eabb_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [eabb_pkg::PIX_W-1:0]     in_tdata,   // in_red, in_green, in_blue
  input  logic                           in_tuser,   // drain
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [eabb_pkg::PIX_W-1:0]     out_tdata,  // out_red, out_green, out_blue
  input  logic                           out_tlast,
  output int                             mismatches,
  output int                             pending,
  output int                             checked
);
  import eabb_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;

  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } blurred_px_t;

  pix_t             upper_store [MAX_W];
  pix_t             lower_store [MAX_W];
  pix_t             window [9];
  int unsigned      in_row;
  int unsigned      in_col;
  int unsigned      out_row;
  int unsigned      out_col;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  blurred_px_t      blurred_due [$];

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  task automatic take_pixel(input pix_t px, input logic drain);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned n;
    int unsigned sum [3];
    pix_t        v;
    pix_t        fresh;
    bit          emit;
    bit          last;
    blurred_px_t res;
    w = active_width();
    h = active_height();
    fresh = px;
    // Drains are ignored until the whole frame is in; after that every item acts as one.
    if (in_row < h) begin
      if (drain) return;
    end else begin
      fresh = '0;
    end
    c = in_col;
    for (int r = 0; r < 3; r++) begin
      window[r * 3] = window[r * 3 + 1];
      window[r * 3 + 1] = window[r * 3 + 2];
    end
    window[2] = upper_store[c];
    window[5] = lower_store[c];
    window[8] = fresh;
    upper_store[c] = lower_store[c];
    lower_store[c] = fresh;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    sum = '{0, 0, 0};
    n = 0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (r == 0 && out_row < 1) continue;
        if (r == 2 && out_row + 1 >= h) continue;
        if (k == 0 && out_col < 1) continue;
        if (k == 2 && out_col + 1 >= w) continue;
        v = window[r * 3 + k];
        for (int ch = 0; ch < 3; ch++) sum[ch] += v[ch * 8 +: 8];
        n++;
      end
    end
    res.red = 8'((2 * sum[0] + n) / (2 * n));
    res.green = 8'((2 * sum[1] + n) / (2 * n));
    res.blue = 8'((2 * sum[2] + n) / (2 * n));
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    res.last = last;
    blurred_due.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (last) restart_frame();
  endtask

  always @(posedge clk) begin : monitor
    blurred_px_t seen;
    blurred_px_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_W; i++) begin
        upper_store[i] = '0;
        lower_store[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      width_reg = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(1);
      restart_frame();
      blurred_due.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tlast, out_tdata};
        if (blurred_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected blurred pixel r=%0d g=%0d b=%0d last=%0d",
                     seen.red, seen.green, seen.blue, seen.last);
          end
        end else begin
          want = blurred_due.pop_front();
          checked++;
          if (seen.red !== want.red || seen.green !== want.green ||
              seen.blue !== want.blue || seen.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("pixel %0d: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                       checked, want.red, want.green, want.blue, want.last,
                       seen.red, seen.green, seen.blue, seen.last);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_wdata;
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_wdata;
          restart_frame();
        end
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata, in_tuser);
    end
    pending = blurred_due.size();
  end

endmodule

>>> bench/tb_edge_aware_box_blur.sv
// Testbench top for the box blur: drives frames of many sizes and reports the verdict.
`timescale 1ns / 100ps

module tb_edge_aware_box_blur;
  import eabb_pkg::*;

  localparam int RUN_ITEMS     = 1500;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata;   // in_red, in_green, in_blue
  logic                 in_tuser;   // drain
  logic                 out_tvalid;
  logic                 out_tready;
  logic [PIX_W-1:0]     out_tdata;  // out_red, out_green, out_blue
  logic                 out_tlast;

  int mismatches;
  int pending;
  int checked;
  int items_accepted = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  edge_aware_box_blur i_dut (
    .clk,
    .rst_n,
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .in_tvalid,
    .in_tready,
    .in_tdata,
    .in_tuser,
    .out_tvalid,
    .out_tready,
    .out_tdata,
    .out_tlast
  );

  box_blur_checker i_checker (
    .clk,
    .rst_n,
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .in_tvalid,
    .in_tready,
    .in_tdata,
    .in_tuser,
    .out_tvalid,
    .out_tready,
    .out_tdata,
    .out_tlast,
    .mismatches,
    .pending,
    .checked
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (in_tvalid && in_tready) items_accepted++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
        $display("tb_edge_aware_box_blur: done, errors");
        $finish;
      end
    end
  end

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(input bit extreme);
    logic [PIX_W-1:0] px;
    px = PIX_W'($urandom);
    if (extreme) begin
      for (int ch = 0; ch < 3; ch++) begin
        case ($urandom_range(0, 2))
          0: px[ch * 8 +: 8] = 8'h00;
          1: px[ch * 8 +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  task automatic send_item(input logic [PIX_W-1:0] px, input logic drain);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    in_tuser <= drain;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted pixel has come out and the pipeline has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    do begin
      while (pending != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending != 0);
  endtask

  // Sends the pixels of one frame, then the drain items that push out the last line; it stops early at abort_at.
  task automatic send_frame(input int w, input int h, input bit extreme, input int noise_pct,
                            input int abort_at);
    for (int k = 0; k < w * h; k++) begin
      if (k == abort_at) return;
      if ($urandom_range(0, 99) < noise_pct) send_item(make_pixel(extreme), 1'b1);
      send_item(make_pixel(extreme), 1'b0);
      items_sent++;
    end
    for (int k = 0; k <= w; k++) begin
      send_item(make_pixel(extreme), ($urandom_range(0, 99) < noise_pct) ? 1'b0 : 1'b1);
      items_sent++;
    end
    frames_sent++;
  endtask

  task automatic configure_and_send(input logic [CFG_W-1:0] wreg, input logic [CFG_W-1:0] hreg,
                                    input bit extreme, input int noise_pct, input int abort_pct,
                                    input bit squeeze);
    int w;
    int h;
    int abort_at;
    settle();
    write_reg(REG_FRAME_WIDTH, wreg);
    write_reg(REG_FRAME_HEIGHT, hreg);
    if ($urandom_range(0, 99) < 15) begin
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
    end
    w = (wreg == 0) ? 1 : ((wreg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(wreg));
    h = (hreg == 0) ? 1 : int'(hreg);
    abort_at = ($urandom_range(0, 99) < abort_pct) ? int'($urandom_range(0, w * h - 1)) : -1;
    if (squeeze) hold_req = 1'b1;
    send_frame(w, h, extreme, noise_pct, abort_at);
    if (abort_at < 0 && $urandom_range(0, 4) == 0) send_frame(w, h, extreme, noise_pct, -1);
  endtask

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = gap_length();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int roll;
    logic [CFG_W-1:0] wreg;
    logic [CFG_W-1:0] hreg;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The height keeps its reset value of one line in this first frame.
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd2);
    send_item(make_pixel(1'b1), 1'b1);
    send_frame(2, 1, 1'b1, 0, -1);
    configure_and_send(12'd0, 12'd0, 1'b1, 100, 0, 1'b0);
    configure_and_send(12'd3, 12'd3, 1'b1, 25, 0, 1'b0);

    items_sent = 0;
    phase = 0;
    while (items_sent < RUN_ITEMS) begin
      phase++;
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 3) begin
        calm = 1'b1;
        configure_and_send(12'd64, 12'd3, 1'b0, 0, 0, 1'b1);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) wreg = CFG_W'($urandom_range(1, 8));
        else if (roll < 88) wreg = CFG_W'($urandom_range(9, 40));
        else if (roll < 96) wreg = CFG_W'($urandom_range(41, 160));
        else wreg = '0;
        roll = $urandom_range(0, 99);
        if (roll < 70) hreg = CFG_W'($urandom_range(1, 4));
        else if (roll < 92) hreg = CFG_W'($urandom_range(5, 12));
        else if (roll < 97) hreg = CFG_W'($urandom_range(13, 30));
        else hreg = '0;
        configure_and_send(wreg, hreg, ($urandom_range(0, 3) == 0),
                           ($urandom_range(0, 99) < 30) ? 10 : 0, 10, 1'b0);
      end
    end

    settle();
    $display("Checked %0d blurred pixels from %0d accepted items in %0d complete frames.",
             checked, items_accepted, frames_sent);
    $display("Sizes ran from 1x1 up to 160 wide and 30 tall, with restarts and a long output stall.");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_edge_aware_box_blur: done, clean");
    end else begin
      $display("tb_edge_aware_box_blur: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/eabb_pkg.sv
rtl/eabb_line_mem.sv
rtl/eabb_seq.sv
rtl/eabb_window.sv
rtl/eabb_out_fifo.sv
rtl/edge_aware_box_blur.sv
bench/box_blur_checker.sv
bench/tb_edge_aware_box_blur.sv
